/* rtl/tpa_pkg.sv */
// tracker pointing angles: shared widths, constants and the cordic arctangent table
// no dependencies; imported by every module of the block
package tpa_pkg;

	// field widths
	localparam int COORD_W   = 32;
	localparam int DIST_W    = 32;
	localparam int ANGLE_W   = 16;
	localparam int MIN_W     = 16;
	localparam int SQ_W      = 64;
	localparam int ROOT_W    = 32;

	// cordic datapath widths
	localparam int CORDIC_IN_W = 34;
	localparam int CORDIC_W    = 36;
	localparam int ACC_W       = 32;

	// default cordic stage count and side payload width of the square root pipeline
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ISQRT_SIDE_W      = 1 + COORD_W + (COORD_W + 1) + COORD_W;

	// register reset and angle constants
	localparam logic [MIN_W-1:0]       MIN_DIST_RST  = 16'd100;
	localparam logic [2*MIN_W-1:0]     MIN_SQ_RST    = 32'(MIN_DIST_RST * MIN_DIST_RST);
	localparam logic [ACC_W-1:0]       ACC_HALF_TURN = 32'h8000_0000;
	localparam logic [ACC_W-1:0]       ACC_ROUND     = 32'h0000_8000;
	localparam logic [ANGLE_W-1:0]     QUARTER_TURN  = 16'd16384;
	localparam logic signed [ANGLE_W-1:0] ELEV_MAX   = 16'sd16384;
	localparam logic signed [ANGLE_W-1:0] ELEV_MIN   = -16'sd16384;

	// pipeline depth of one cordic unit: pre-rotation, two normalize stages, the micro-rotation stages, rounding
	function automatic int cordic_latency(input int stages);
		return stages + 4;
	endfunction

	// atan(2^-i) in 2^32 units per turn
	function automatic logic [ACC_W-1:0] atan_entry(input logic [4:0] idx);
		logic [ACC_W-1:0] v;
		unique case (idx)
			5'd0:  v = 32'h2000_0000;
			5'd1:  v = 32'h12E4_051D;
			5'd2:  v = 32'h09FB_385B;
			5'd3:  v = 32'h0511_11D4;
			5'd4:  v = 32'h028B_0D43;
			5'd5:  v = 32'h0145_D7E1;
			5'd6:  v = 32'h00A2_F61E;
			5'd7:  v = 32'h0051_7C55;
			5'd8:  v = 32'h0028_BE53;
			5'd9:  v = 32'h0014_5F2E;
			5'd10: v = 32'h000A_2F98;
			5'd11: v = 32'h0005_17CC;
			5'd12: v = 32'h0002_8BE6;
			5'd13: v = 32'h0001_45F3;
			5'd14: v = 32'h0000_A2F9;
			5'd15: v = 32'h0000_517C;
			5'd16: v = 32'h0000_28BE;
			5'd17: v = 32'h0000_145F;
			5'd18: v = 32'h0000_0A2F;
			5'd19: v = 32'h0000_0517;
			5'd20: v = 32'h0000_028B;
			5'd21: v = 32'h0000_0145;
			5'd22: v = 32'h0000_00A2;
			5'd23: v = 32'h0000_0051;
			5'd24: v = 32'h0000_0028;
			5'd25: v = 32'h0000_0014;
			5'd26: v = 32'h0000_000A;
			5'd27: v = 32'h0000_0005;
			5'd28: v = 32'h0000_0002;
			5'd29: v = 32'h0000_0001;
			default: v = 32'h0000_0000;
		endcase
		return v;
	endfunction

endpackage

/* rtl/tpa_isqrt.sv */
// tracker pointing angles: pipelined rounded square root of a 64-bit sum, one bit per stage
// depends on tpa_pkg; carries a side payload and a valid bit alongside the root
module tpa_isqrt
	import tpa_pkg::*;
#(
	parameter int SIDE_W = ISQRT_SIDE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [SQ_W-1:0]   n,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] side_out
);

	localparam int RW = SQ_W + 2;

	logic              vld_s  [0:ROOT_W-1];
	logic [SQ_W-1:0]   rem_s  [0:ROOT_W-1];
	logic [ROOT_W-1:0] root_s [0:ROOT_W-1];
	logic [SIDE_W-1:0] side_s [0:ROOT_W-1];

	// one root bit per stage, most significant first
	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		localparam int J = ROOT_W - 1 - k;
		logic              vld_in;
		logic [SQ_W-1:0]   rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SIDE_W-1:0] side_k;
		logic [RW-1:0]     trial;
		logic              take;

		if (k == 0) begin : g_first
			assign vld_in  = in_vld;
			assign rem_in  = n;
			assign root_in = '0;
			assign side_k  = side_in;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign side_k  = side_s[k-1];
		end

		// (r + 2^j)^2 - r^2 = r*2^(j+1) + 2^(2j)
		assign trial = (RW'(root_in) << (J + 1)) + (RW'(1) << (2 * J));
		assign take  = ({2'b00, rem_in} >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? SQ_W'({2'b00, rem_in} - trial) : rem_in;
				root_s[k] <= take ? (root_in | (ROOT_W'(1) << J)) : root_in;
				side_s[k] <= side_k;
			end
		end
	end

	// round to nearest: remainder above the floor root means the upper neighbor is closer
	logic [ROOT_W:0] root_up;
	assign root_up = {1'b0, root_s[ROOT_W-1]} + (ROOT_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[ROOT_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			root     <= (rem_s[ROOT_W-1] > SQ_W'(root_s[ROOT_W-1])) ?
			            root_up[ROOT_W-1:0] : root_s[ROOT_W-1];
			side_out <= side_s[ROOT_W-1];
		end
	end

endmodule

/* rtl/tpa_cordic.sv */
// tracker pointing angles: pipelined vectoring cordic giving atan2(b, a) in 16-bit binary angle
// depends on tpa_pkg for widths and the arctangent table
module tpa_cordic
	import tpa_pkg::*;
#(
	parameter int STAGES = CORDIC_STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [CORDIC_IN_W-1:0] a_in,
	input  logic signed [CORDIC_IN_W-1:0] b_in,
	output logic        [ANGLE_W-1:0]     angle
);

	localparam int CW = CORDIC_W;

	// pre-rotation: turn a vector in the left half plane by half a turn
	logic signed [CW-1:0] a_ext, b_ext, a_neg, b_neg;
	logic        [CW-1:0] mag_a, mag_b;

	assign a_ext = {{(CW-CORDIC_IN_W){a_in[CORDIC_IN_W-1]}}, a_in};
	assign b_ext = {{(CW-CORDIC_IN_W){b_in[CORDIC_IN_W-1]}}, b_in};
	assign a_neg = -a_ext;
	assign b_neg = -b_ext;
	assign mag_a = a_ext[CW-1] ? a_neg : a_ext;
	assign mag_b = b_ext[CW-1] ? b_neg : b_ext;

	logic signed [CW-1:0] a_s1, b_s1;
	logic        [CW-1:0] o_s1;
	logic     [ACC_W-1:0] acc_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= a_ext[CW-1] ? a_neg : a_ext;
			b_s1   <= a_ext[CW-1] ? b_neg : b_ext;
			acc_s1 <= a_ext[CW-1] ? ACC_HALF_TURN : '0;
			o_s1   <= mag_a | mag_b;
		end
	end

	// normalize, coarse steps: the or of both magnitudes has the larger one's leading bit
	logic                 sh16, sh8;
	logic signed [CW-1:0] a_m, b_m, a_n1, b_n1;
	logic        [CW-1:0] o_m, o_n1;

	always_comb begin
		sh16 = (o_s1[CW-1:15] == '0);
		a_m  = sh16 ? (a_s1 <<< 16) : a_s1;
		b_m  = sh16 ? (b_s1 <<< 16) : b_s1;
		o_m  = sh16 ? (o_s1 << 16) : o_s1;
		sh8  = (o_m[CW-1:23] == '0);
		a_n1 = sh8 ? (a_m <<< 8) : a_m;
		b_n1 = sh8 ? (b_m <<< 8) : b_m;
		o_n1 = sh8 ? (o_m << 8) : o_m;
	end

	logic signed [CW-1:0] a_s2, b_s2;
	logic        [CW-1:0] o_s2;
	logic     [ACC_W-1:0] acc_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2   <= a_n1;
			b_s2   <= b_n1;
			o_s2   <= o_n1;
			acc_s2 <= acc_s1;
		end
	end

	// normalize, fine steps: larger magnitude ends at or above 2^30
	logic                 sh4, sh2, sh1;
	logic signed [CW-1:0] a_f4, b_f4, a_f2, b_f2, a_f1, b_f1;
	logic        [CW-1:0] o_f4, o_f2;

	always_comb begin
		sh4  = (o_s2[CW-1:27] == '0);
		a_f4 = sh4 ? (a_s2 <<< 4) : a_s2;
		b_f4 = sh4 ? (b_s2 <<< 4) : b_s2;
		o_f4 = sh4 ? (o_s2 << 4) : o_s2;
		sh2  = (o_f4[CW-1:29] == '0);
		a_f2 = sh2 ? (a_f4 <<< 2) : a_f4;
		b_f2 = sh2 ? (b_f4 <<< 2) : b_f4;
		o_f2 = sh2 ? (o_f4 << 2) : o_f4;
		sh1  = (o_f2[CW-1:30] == '0);
		a_f1 = sh1 ? (a_f2 <<< 1) : a_f2;
		b_f1 = sh1 ? (b_f2 <<< 1) : b_f2;
	end

	logic signed [CW-1:0] it_a_s   [0:STAGES];
	logic signed [CW-1:0] it_b_s   [0:STAGES];
	logic     [ACC_W-1:0] it_acc_s [0:STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			it_a_s[0]   <= a_f1;
			it_b_s[0]   <= b_f1;
			it_acc_s[0] <= acc_s2;
		end
	end

	// micro-rotations, one per stage, driving b toward zero
	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		localparam int SH = i % 32;
		localparam logic [ACC_W-1:0] ANG = atan_entry(5'(SH));
		logic signed [CW-1:0] da, db;
		logic                 b_pos;

		assign da    = it_b_s[i] >>> SH;
		assign db    = it_a_s[i] >>> SH;
		assign b_pos = !it_b_s[i][CW-1] && (it_b_s[i] != '0);

		always_ff @(posedge clk) begin
			if (en) begin
				it_a_s[i+1]   <= b_pos ? (it_a_s[i] + da) : (it_a_s[i] - da);
				it_b_s[i+1]   <= b_pos ? (it_b_s[i] - db) : (it_b_s[i] + db);
				it_acc_s[i+1] <= b_pos ? (it_acc_s[i] + ANG) : (it_acc_s[i] - ANG);
			end
		end
	end

	// round the accumulator to 16-bit binary angle
	logic [ACC_W-1:0] acc_rnd;
	assign acc_rnd = it_acc_s[STAGES] + ACC_ROUND;

	always_ff @(posedge clk) begin
		if (en) begin
			angle <= acc_rnd[ACC_W-1:ACC_W-ANGLE_W];
		end
	end

endmodule

/* rtl/tracker_pointing_angles_top.sv */
// tracker pointing angles: top level with stream ports, squaring front end and output register
// depends on tpa_pkg, tpa_isqrt and tpa_cordic
//
// Antenna tracker pointing: a request on the slave stream carries an aircraft offset
// from home (x, y, z in mm); a request on the master stream returns the horizontal
// distance, bearing (65536 units per turn) and elevation (16384 units per quarter turn).
// Inside the minimum distance register the bearing is 0 and the elevation straight up.
// Throughput is one request per cycle while the master side does not stall: squares,
// sum, 32 square root stages and two cordic units side by side are fully pipelined,
// every stage registered. From input accept to output valid a request passes 3
// front-end stages, 33 square root stages, CORDIC_STAGES + 4 cordic stages and the
// output register. A stall on the master side freezes the whole pipeline at once;
// s_axis_tready drops while a result waits in the output register and m_axis_tready
// is low, and nothing is lost or repeated. Bubbles flow through with their valid bits
// low. Reset clears all valid bits and loads the minimum distance of 100 mm. The
// minimum distance is written through cfg_we / cfg_wdata; the user must do so only
// while no request is in flight, as the block itself does not enforce it.
module tracker_pointing_angles_top
	import tpa_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [MIN_W-1:0]     cfg_wdata,        // min_distance_mm
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [3*COORD_W-1:0] s_axis_tdata,     // pos_x, pos_y, pos_z
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [63:0]          m_axis_tdata      // ground_distance_mm, bearing_angle, elevation_angle
);

	localparam int CORDIC_LAT = cordic_latency(CORDIC_STAGES);

	logic en;
	logic out_vld_q;

	// whole pipeline advances unless a result waits on a stalled receiver
	assign en            = !out_vld_q || m_axis_tready;
	assign s_axis_tready = en;

	// squared minimum distance, kept ready for the compare
	logic [2*MIN_W-1:0] min_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_sq_q <= MIN_SQ_RST;
		end else if (cfg_we) begin
			min_sq_q <= cfg_wdata * cfg_wdata;
		end
	end

	// stage 1: unpack, magnitudes of x and y, negated y for the bearing
	logic [COORD_W-1:0] px, py, pz;
	assign px = s_axis_tdata[COORD_W-1:0];
	assign py = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign pz = s_axis_tdata[3*COORD_W-1:2*COORD_W];

	logic                      vld_s1;
	logic        [COORD_W-1:0] ax_s1, ay_s1;
	logic signed [COORD_W-1:0] x_s1, z_s1;
	logic signed [COORD_W:0]   ny_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= px[COORD_W-1] ? (~px + COORD_W'(1)) : px;
			ay_s1 <= py[COORD_W-1] ? (~py + COORD_W'(1)) : py;
			x_s1  <= px;
			z_s1  <= pz;
			ny_s1 <= -$signed({py[COORD_W-1], py});
		end
	end

	// stage 2: squares
	logic                      vld_s2;
	logic           [SQ_W-1:0] sqx_s2, sqy_s2;
	logic signed [COORD_W-1:0] x_s2, z_s2;
	logic signed [COORD_W:0]   ny_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2 <= ax_s1 * ax_s1;
			sqy_s2 <= ay_s1 * ay_s1;
			x_s2   <= x_s1;
			ny_s2  <= ny_s1;
			z_s2   <= z_s1;
		end
	end

	// stage 3: sum of squares and near-home compare
	logic                      vld_s3;
	logic                      near_s3;
	logic           [SQ_W-1:0] sum_s3;
	logic signed [COORD_W-1:0] x_s3, z_s3;
	logic signed [COORD_W:0]   ny_s3;
	logic           [SQ_W-1:0] sum_sq;

	assign sum_sq = sqx_s2 + sqy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sum_sq;
			near_s3 <= (sum_sq <= SQ_W'(min_sq_q));
			x_s3    <= x_s2;
			ny_s3   <= ny_s2;
			z_s3    <= z_s2;
		end
	end

	// ground distance
	logic                    sq_vld;
	logic [ROOT_W-1:0]       gnd_dist;
	logic [ISQRT_SIDE_W-1:0] sq_side;
	logic                    sq_near;
	logic [COORD_W-1:0]      sq_x, sq_z;
	logic [COORD_W:0]        sq_ny;

	tpa_isqrt #(
		.SIDE_W (ISQRT_SIDE_W)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.n        (sum_s3),
		.side_in  ({near_s3, z_s3, ny_s3, x_s3}),
		.out_vld  (sq_vld),
		.root     (gnd_dist),
		.side_out (sq_side)
	);

	assign {sq_near, sq_z, sq_ny, sq_x} = sq_side;

	// bearing and elevation cordic units run side by side
	logic [ANGLE_W-1:0] ang_b, ang_e;

	tpa_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic_bearing (
		.clk   (clk),
		.en    (en),
		.a_in  ({{(CORDIC_IN_W-COORD_W){sq_x[COORD_W-1]}}, sq_x}),
		.b_in  ({{(CORDIC_IN_W-COORD_W-1){sq_ny[COORD_W]}}, sq_ny}),
		.angle (ang_b)
	);

	tpa_cordic #(
		.STAGES (CORDIC_STAGES)
	) u_cordic_elev (
		.clk   (clk),
		.en    (en),
		.a_in  ({{(CORDIC_IN_W-ROOT_W){1'b0}}, gnd_dist}),
		.b_in  ({{(CORDIC_IN_W-COORD_W){sq_z[COORD_W-1]}}, sq_z}),
		.angle (ang_e)
	);

	// distance, near flag and valid follow the cordic latency
	logic              dly_vld_s  [0:CORDIC_LAT-1];
	logic              dly_near_s [0:CORDIC_LAT-1];
	logic [DIST_W-1:0] dly_dist_s [0:CORDIC_LAT-1];

	for (genvar k = 0; k < CORDIC_LAT; k++) begin : g_dly
		logic              vld_in, near_in;
		logic [DIST_W-1:0] dist_in;

		if (k == 0) begin : g_first
			assign vld_in  = sq_vld;
			assign near_in = sq_near;
			assign dist_in = gnd_dist;
		end else begin : g_next
			assign vld_in  = dly_vld_s[k-1];
			assign near_in = dly_near_s[k-1];
			assign dist_in = dly_dist_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dly_vld_s[k] <= 1'b0;
			end else if (en) begin
				dly_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dly_near_s[k] <= near_in;
				dly_dist_s[k] <= dist_in;
			end
		end
	end

	// final angles: quarter-turn offset, elevation clamp, near-home override
	logic        [ANGLE_W-1:0] bearing;
	logic signed [ANGLE_W-1:0] elev;

	always_comb begin
		bearing = ang_b + QUARTER_TURN;
		elev    = $signed(ang_e);
		if (elev > ELEV_MAX) begin
			elev = ELEV_MAX;
		end else if (elev < ELEV_MIN) begin
			elev = ELEV_MIN;
		end
		if (dly_near_s[CORDIC_LAT-1]) begin
			bearing = '0;
			elev    = ELEV_MAX;
		end
	end

	// output register
	logic [63:0] out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= dly_vld_s[CORDIC_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {elev, bearing, dly_dist_s[CORDIC_LAT-1]};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule
